@@ rtl/core/mdt_pkg.sv @@
// ----------------------------------------------------------------------------
// mdt_pkg
// Shared types, constants and byte helpers of the dependency file tokenizer.
// ----------------------------------------------------------------------------
`default_nettype none

package mdt_pkg;

  localparam int LINE_MAX_DEF = 32;

  localparam logic [7:0] CH_PAD   = 8'hFF;
  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SP    = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_VT    = 8'h0B;
  localparam logic [7:0] CH_FF    = 8'h0C;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_EQ    = 8'h3D;
  localparam logic [7:0] CH_BAR   = 8'h7C;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_BSL   = 8'h5C;

  localparam logic [2:0] PM_FULL = 3'd6;
  localparam logic [2:0] PM_MISS = 3'd7;

  typedef enum logic [1:0] {
    KIND_TARGET = 2'd0,
    KIND_NORMAL = 2'd1,
    KIND_PHONY  = 2'd2,
    KIND_ORDER  = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    SEC_TARGET = 2'd0,
    SEC_DEPS   = 2'd1,
    SEC_ORDER  = 2'd2
  } section_t;

  typedef enum logic [1:0] {
    LP_CHECK = 2'd0,
    LP_DROP  = 2'd1,
    LP_OFF   = 2'd2
  } line_phase_t;

  // line decision class of a byte
  typedef enum logic [1:0] {
    CLS_NONE   = 2'd0,
    CLS_END    = 2'd1,
    CLS_ASSIGN = 2'd2
  } cls_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RUN,
    ST_FETCH,
    ST_FILL,
    ST_SCAN,
    ST_SCAN_CHK,
    ST_FLUSH
  } state_t;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       end_of_input;
  } in_item_t;

  typedef struct packed {
    logic [7:0] path_char;
    logic [1:0] item_kind;
    logic       word_last;
    logic       finished;
    logic       run_last;
  } out_item_t;

  typedef struct packed {
    in_item_t item;
    cls_t     cls;
  } front_word_t;

  function automatic cls_t byte_cls(input logic [7:0] b);
    cls_t c;
    c = CLS_NONE;
    if (b == CH_NL || b == CH_CR || b == CH_COLON) c = CLS_END;
    else if (b == CH_EQ) c = CLS_ASSIGN;
    return c;
  endfunction

  function automatic logic [7:0] phony_at(input logic [2:0] i);
    logic [7:0] c;
    case (i)
      3'd0: c = 8'h2E;
      3'd1: c = 8'h50;
      3'd2: c = 8'h48;
      3'd3: c = 8'h4F;
      3'd4: c = 8'h4E;
      3'd5: c = 8'h59;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  function automatic logic is_sep(input logic [7:0] b);
    return b == CH_SP || b == CH_TAB || b == CH_NL || b == CH_VT || b == CH_FF || b == CH_CR;
  endfunction

  function automatic logic is_blank(input logic [7:0] b);
    return b == CH_SP || b == CH_TAB || b == CH_VT || b == CH_FF;
  endfunction

endpackage

`default_nettype wire

@@ rtl/core/mdt_ram.sv @@
// ----------------------------------------------------------------------------
// mdt_ram
// Generic single write, single read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module mdt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] wa,
  input  wire logic [WIDTH-1:0]         wd,
  input  wire logic [$clog2(DEPTH)-1:0] ra,
  output      logic [WIDTH-1:0]         rd
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    rd <= mem[ra];
  end

endmodule

`default_nettype wire

@@ rtl/core/mdt_front.sv @@
// ----------------------------------------------------------------------------
// mdt_front
// Input side: takes bytes, tags their line class, two-word queue to the back.
// ----------------------------------------------------------------------------
`default_nettype none

module mdt_front import mdt_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        byte_valid,
  output      logic        byte_stall,
  input  wire in_item_t    byte_item,
  output      logic        q_avail,
  output      front_word_t q_word,
  input  wire logic        q_pop
);

  front_word_t e0, e1;
  logic [1:0]  n;
  logic        push;
  front_word_t nw;

  assign byte_stall = (n == 2'd2);
  assign push       = byte_valid && !byte_stall;
  assign nw.item    = byte_item;
  assign nw.cls     = byte_cls(byte_item.in_byte);
  assign q_avail    = (n != 2'd0);
  assign q_word     = e0;

  always_ff @(posedge clk) begin
    if (rst) begin
      n <= 2'd0;
    end else begin
      case ({push, q_pop && q_avail})
        2'b10: n <= n + 2'd1;
        2'b01: n <= n - 2'd1;
        default: n <= n;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop && q_avail) begin
      e0 <= (push && n == 2'd1) ? nw : e1;
      if (push && n == 2'd2) e1 <= nw;
    end else if (push) begin
      if (n == 2'd0) e0 <= nw;
      else e1 <= nw;
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/mdt_back.sv @@
// ----------------------------------------------------------------------------
// mdt_back
// Tokenizer sequencer: line buffer, lookahead window, word state, output.
// ----------------------------------------------------------------------------
`default_nettype none

module mdt_back import mdt_pkg::*; #(
  parameter int LINE_MAX = LINE_MAX_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        q_avail,
  input  wire front_word_t q_word,
  output      logic        q_pop,
  output      logic        token_valid,
  input  wire logic        token_stall,
  output      out_item_t   token_item
);

  localparam int AW = $clog2(LINE_MAX);
  localparam int CW = $clog2(LINE_MAX + 1);
  localparam logic [CW:0] LM = (CW+1)'(LINE_MAX);

  state_t      state, state_next;
  logic [AW-1:0] head;
  logic [CW-1:0] cnt, scan_ok;
  cls_t        scan_cls;
  logic [1:0]  wn, wneed;
  logic [7:0]  w0, w1, w2;
  section_t    section, sec_n;
  logic        phony_rule, pr_n;
  line_phase_t line_phase, lp_n;
  logic        held_v, hv_n;
  logic [7:0]  held_c, hc_n;
  logic [2:0]  pm, pm_n;
  logic        word_open, wo_n;
  logic        done;
  logic        eof_r;
  logic        pend_v;
  out_item_t   pend;
  logic        out_v;
  out_item_t   out_r;
  logic        out_free;
  logic        out_load;
  out_item_t   out_d;

  logic        we;
  logic [AW-1:0] wa, ra;
  logic [7:0]  rd;

  logic [7:0]  c0, c1, c2;
  logic        h1, h2, h3;
  logic        s_end, s_scan, s_fin, s_stall;
  logic [1:0]  s_eat;
  logic        e_v, e_last, e_fin;
  logic [7:0]  e_c;
  logic [1:0]  kind;
  cls_t        r;
  logic        rest;
  logic        push_v;
  logic [7:0]  push_c;
  logic        endw;
  out_item_t   e_item;

  function automatic logic [AW-1:0] wrap(input logic [CW:0] s);
    return (s >= LM) ? AW'(s - LM) : AW'(s);
  endfunction

  mdt_ram #(.WIDTH(8), .DEPTH(LINE_MAX)) u_ram (
    .clk(clk), .we(we), .wa(wa), .wd(q_word.item.in_byte), .ra(ra), .rd(rd)
  );

  assign wneed    = (cnt >= CW'(3)) ? 2'd3 : cnt[1:0];
  assign out_free = !out_v || !token_stall;
  assign c0 = (cnt >= CW'(1)) ? w0 : CH_PAD;
  assign c1 = (cnt >= CW'(2)) ? w1 : CH_PAD;
  assign c2 = (cnt >= CW'(3)) ? w2 : CH_PAD;
  assign h1 = eof_r || cnt >= CW'(1);
  assign h2 = eof_r || cnt >= CW'(2);
  assign h3 = eof_r || cnt >= CW'(3);
  assign kind = (section == SEC_TARGET) ? KIND_TARGET :
                (section == SEC_DEPS) ? (phony_rule ? KIND_PHONY : KIND_NORMAL) : KIND_ORDER;

  assign q_pop = (state == ST_IDLE) && q_avail;
  assign we    = q_pop && !done && !q_word.item.end_of_input && cnt < CW'(LINE_MAX);
  assign wa    = wrap({1'b0, head} + (CW+1)'(cnt));
  assign ra    = wrap({1'b0, head} + (CW+1)'((state == ST_SCAN) ? scan_ok : CW'(wn)));

  // one pass of the tokenizer loop
  always_comb begin
    s_end = 1'b0; s_scan = 1'b0; s_fin = 1'b0; s_eat = 2'd0;
    sec_n = section; pr_n = phony_rule; lp_n = line_phase;
    hv_n = held_v; hc_n = held_c; pm_n = pm; wo_n = word_open;
    push_v = 1'b0; push_c = c0; endw = 1'b0; rest = 1'b0;
    r = CLS_NONE;
    if (done) begin
      s_end = 1'b1;
    end else if (line_phase == LP_DROP) begin
      if (cnt == '0) begin
        s_end = 1'b1;
        s_fin = eof_r;
      end else begin
        s_eat = 2'd1;
        if (w0 == CH_NL) lp_n = LP_CHECK;
      end
    end else if (word_open) begin
      if (!h1 || ((c0 == CH_COLON || c0 == CH_BSL) && !h2)) begin
        s_end = 1'b1;
      end else if (c0 == CH_PAD || is_sep(c0) || c0 == CH_BAR) begin
        endw = 1'b1;
      end else if (c0 == CH_COLON) begin
        if (c1 == CH_SLASH || c1 == CH_BSL) begin
          s_eat = 2'd1; push_v = 1'b1; push_c = CH_COLON;
        end else begin
          endw = 1'b1;
        end
      end else if (c0 == CH_BSL) begin
        if (c1 == CH_SP) begin
          s_eat = 2'd2; push_v = 1'b1; push_c = CH_SP;
        end else if (c1 == CH_CR || c1 == CH_NL) begin
          endw = 1'b1;
        end else begin
          s_eat = 2'd1; push_v = 1'b1; push_c = CH_SLASH;
        end
      end else begin
        s_eat = 2'd1; push_v = 1'b1; push_c = c0;
      end
    end else begin
      if (!h1) begin
        s_end = 1'b1;
      end else if (is_blank(c0)) begin
        s_eat = 2'd1;
      end else if (c0 == CH_BSL && !h2) begin
        s_end = 1'b1;
      end else if (c0 == CH_BSL && c1 == CH_NL) begin
        s_eat = 2'd2;
      end else if (c0 == CH_BSL && c1 == CH_CR) begin
        if (!h3) s_end = 1'b1;
        else s_eat = (c2 == CH_NL) ? 2'd3 : 2'd2;
      end else begin
        rest = 1'b1;
      end
      if (rest && section == SEC_TARGET) begin
        if (cnt == '0 && eof_r) begin
          s_fin = 1'b1; s_end = 1'b1; rest = 1'b0;
        end else if (line_phase == LP_CHECK) begin
          if (scan_cls != CLS_NONE) r = scan_cls;
          else if (scan_ok < cnt) begin
            s_scan = 1'b1; rest = 1'b0;
          end
          if (rest) begin
            if (r == CLS_ASSIGN) begin
              lp_n = LP_DROP; rest = 1'b0;
            end else if (r == CLS_NONE && !eof_r) begin
              if (cnt >= CW'(LINE_MAX)) lp_n = LP_OFF;
              else begin
                s_end = 1'b1; rest = 1'b0;
              end
            end
          end
        end
      end
      if (rest) begin
        if (c0 == CH_PAD) begin
          s_fin = 1'b1; s_end = 1'b1;
        end else if (c0 == CH_COLON) begin
          s_eat = 2'd1; sec_n = SEC_DEPS;
        end else if (c0 == CH_BAR) begin
          s_eat = 2'd1; sec_n = SEC_ORDER;
        end else if (c0 == CH_CR && !h2) begin
          s_end = 1'b1;
        end else if (c0 == CH_CR || c0 == CH_NL) begin
          s_eat = (c0 == CH_CR && c1 == CH_NL) ? 2'd2 : 2'd1;
          sec_n = SEC_TARGET; pr_n = 1'b0; lp_n = LP_CHECK;
        end else begin
          wo_n = 1'b1; pm_n = 3'd0; hv_n = 1'b0;
        end
      end
    end
    if (push_v) begin
      hv_n = 1'b1; hc_n = push_c;
      pm_n = (pm < PM_FULL && push_c == phony_at(pm)) ? pm + 3'd1 : PM_MISS;
    end
    if (endw) begin
      hv_n = 1'b0;
      if (section == SEC_TARGET && pm == PM_FULL) pr_n = 1'b1;
      pm_n = 3'd0; wo_n = 1'b0;
    end
    e_v    = s_fin || ((push_v || endw) && held_v);
    e_fin  = s_fin;
    e_last = endw;
    e_c    = s_fin ? 8'h00 : held_c;
    e_item.path_char = e_c;
    e_item.item_kind = e_fin ? KIND_TARGET : kind;
    e_item.word_last = e_last;
    e_item.finished  = e_fin;
    e_item.run_last  = 1'b0;
    s_stall = e_v && pend_v && !out_free;
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:     if (q_avail && !done) state_next = ST_RUN;
      ST_RUN: begin
        if (wn != wneed) state_next = ST_FETCH;
        else if (s_stall) state_next = ST_RUN;
        else if (s_end) state_next = ST_FLUSH;
        else if (s_scan) state_next = ST_SCAN;
      end
      ST_FETCH:    state_next = ST_FILL;
      ST_FILL:     state_next = ST_RUN;
      ST_SCAN:     state_next = ST_SCAN_CHK;
      ST_SCAN_CHK: state_next = ST_RUN;
      ST_FLUSH:    if (!pend_v || out_free) state_next = ST_IDLE;
      default:     state_next = ST_IDLE;
    endcase
  end

  // output register load: older pending word, or the last one of the byte
  always_comb begin
    out_load = 1'b0;
    out_d    = pend;
    if (state == ST_RUN && wn == wneed && !s_stall && !s_scan && e_v && pend_v) begin
      out_load = 1'b1;
    end
    if (state == ST_FLUSH && pend_v && out_free) begin
      out_load = 1'b1;
      out_d.run_last = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_v <= 1'b0;
    end else if (out_load) begin
      out_v <= 1'b1;
    end else if (!token_stall) begin
      out_v <= 1'b0;
    end
    if (out_load) out_r <= out_d;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      head <= '0; cnt <= '0; wn <= 2'd0;
      scan_ok <= '0; scan_cls <= CLS_NONE;
      section <= SEC_TARGET; phony_rule <= 1'b0; line_phase <= LP_CHECK;
      held_v <= 1'b0; pm <= 3'd0; word_open <= 1'b0; done <= 1'b0;
      eof_r <= 1'b0; pend_v <= 1'b0;
    end else begin
      state <= state_next;
      case (state)
        ST_IDLE: begin
          if (q_pop) begin
            eof_r <= q_word.item.end_of_input;
            if (we) begin
              cnt <= cnt + CW'(1);
              if (scan_ok == cnt && scan_cls == CLS_NONE) scan_cls <= q_word.cls;
            end
          end
        end
        ST_FILL: begin
          case (wn)
            2'd0: w0 <= rd;
            2'd1: w1 <= rd;
            default: w2 <= rd;
          endcase
          wn <= wn + 2'd1;
        end
        ST_SCAN_CHK: begin
          if (byte_cls(rd) != CLS_NONE) scan_cls <= byte_cls(rd);
          else scan_ok <= scan_ok + CW'(1);
        end
        ST_RUN: begin
          if (wn == wneed && !s_stall && !s_scan) begin
            section <= sec_n; phony_rule <= pr_n; line_phase <= lp_n;
            held_v <= hv_n; held_c <= hc_n; pm <= pm_n; word_open <= wo_n;
            if (e_v) begin
              pend <= e_item; pend_v <= 1'b1;
            end
            if (s_fin) begin
              done <= 1'b1; cnt <= '0; wn <= 2'd0;
              scan_ok <= '0; scan_cls <= CLS_NONE;
            end else if (s_eat != 2'd0) begin
              head <= wrap({1'b0, head} + (CW+1)'(s_eat));
              cnt  <= cnt - CW'(s_eat);
              wn   <= wn - s_eat;
              case (s_eat)
                2'd1: begin
                  w0 <= w1; w1 <= w2;
                end
                2'd2: w0 <= w2;
                default: w0 <= w0;
              endcase
              if (scan_ok >= CW'(s_eat)) scan_ok <= scan_ok - CW'(s_eat);
              else begin
                scan_ok <= '0; scan_cls <= CLS_NONE;
              end
            end
          end
        end
        ST_FLUSH: begin
          if (pend_v && out_free) pend_v <= 1'b0;
        end
        default: ;
      endcase
    end
  end

  assign token_valid = out_v;
  assign token_item  = out_r;

endmodule

`default_nettype wire

@@ rtl/core/make_depfile_tokenizer_unit.sv @@
// ----------------------------------------------------------------------------
// make_depfile_tokenizer_unit
// Splits a make dependency file, one byte per word in, into tagged path
// characters out.
// ----------------------------------------------------------------------------
// One input byte is handled at a time. The byte is taken into the line
// buffer, then the tokenizer runs one or more steps (more when a buffered
// line start is replayed); the last step finds no more work. A lookahead
// byte is fetched from the line buffer RAM by a fetch and a fill state, a
// buffered byte examined while a line start is decided as an assignment or
// not by a scan and a scan check state, all on the RAM's single read port.
// A flush state hands the byte's last word to the output register. A step
// or the flush waits while the output register is full and stalled. A
// two-word input queue and an output register let both sides stall on
// their own. No clearing pass is needed after reset.
`default_nettype none

module make_depfile_tokenizer_unit import mdt_pkg::*; #(
  parameter int LINE_MAX = LINE_MAX_DEF
) (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      byte_valid,
  output      logic      byte_stall,
  input  wire in_item_t  byte_item,
  output      logic      token_valid,
  input  wire logic      token_stall,
  output      out_item_t token_item
);

  logic        q_avail;
  logic        q_pop;
  front_word_t q_word;

  mdt_front u_front (
    .clk(clk), .rst(rst),
    .byte_valid(byte_valid), .byte_stall(byte_stall), .byte_item(byte_item),
    .q_avail(q_avail), .q_word(q_word), .q_pop(q_pop)
  );

  mdt_back #(.LINE_MAX(LINE_MAX)) u_back (
    .clk(clk), .rst(rst),
    .q_avail(q_avail), .q_word(q_word), .q_pop(q_pop),
    .token_valid(token_valid), .token_stall(token_stall), .token_item(token_item)
  );

endmodule

`default_nettype wire

@@ tb/tb_make_depfile_tokenizer_unit.sv @@
// ----------------------------------------------------------------------------
// tb_make_depfile_tokenizer_unit
// Self-checking bench for the dependency file tokenizer: directed lines,
// random make rules with noise, stalls on both sides and a long output hold.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_make_depfile_tokenizer_unit;
  import mdt_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int LMAX = LINE_MAX_DEF;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      byte_valid = 1'b0;
  logic      byte_stall;
  in_item_t  byte_item = '0;
  logic      token_valid;
  logic      token_stall = 1'b0;
  out_item_t token_item;

  make_depfile_tokenizer_unit dut (
    .clk(clk), .rst(rst),
    .byte_valid(byte_valid), .byte_stall(byte_stall), .byte_item(byte_item),
    .token_valid(token_valid), .token_stall(token_stall), .token_item(token_item)
  );

  always #10 clk = ~clk;

  // tokenizer state mirror
  logic [7:0]  lbuf[LMAX];
  int          lcnt;
  section_t    sec;
  logic        phony;
  line_phase_t lphase;
  logic [8:0]  held;
  logic [2:0]  pmatch;
  logic        wopen;
  logic        done;

  out_item_t   tokens_due[$];
  out_item_t   step_out[$];

  int  errors = 0;
  int  words_sent = 0;
  int  tokens_seen = 0;
  int  send_idle_pct = 0;
  int  recv_idle_pct = 0;
  bit  hold_off = 0;

  function automatic logic [7:0] peek_at(int i);
    return (i < lcnt) ? lbuf[i] : CH_PAD;
  endfunction

  function automatic void eat(int k);
    if (k > lcnt) k = lcnt;
    for (int i = 0; i + k < lcnt; i++) lbuf[i] = lbuf[i + k];
    lcnt -= k;
  endfunction

  function automatic void emit(logic [7:0] ch, logic lst, logic fin);
    out_item_t o;
    o.path_char = ch;
    o.item_kind = fin ? KIND_TARGET :
                  (sec == SEC_TARGET) ? KIND_TARGET :
                  (sec == SEC_DEPS) ? (phony ? KIND_PHONY : KIND_NORMAL) : KIND_ORDER;
    o.word_last = lst;
    o.finished = fin;
    o.run_last = 1'b0;
    if (step_out.size() < 64) step_out.push_back(o);
  endfunction

  function automatic void push_char(logic [7:0] ch);
    if (held[8]) emit(held[7:0], 1'b0, 1'b0);
    held = {1'b1, ch};
    if (pmatch < PM_FULL && ch == phony_at(pmatch)) pmatch++;
    else pmatch = PM_MISS;
  endfunction

  function automatic void end_word();
    if (held[8]) emit(held[7:0], 1'b1, 1'b0);
    held = '0;
    if (sec == SEC_TARGET && pmatch == PM_FULL) phony = 1'b1;
    pmatch = '0;
    wopen = 1'b0;
  endfunction

  function automatic void finish_parse();
    done = 1'b1;
    lcnt = 0;
    emit(8'h00, 1'b0, 1'b1);
  endfunction

  // 0 undecided, 1 plain line, 2 assignment
  function automatic int decide_line();
    for (int i = 0; i < lcnt; i++) begin
      if (lbuf[i] == CH_NL || lbuf[i] == CH_CR || lbuf[i] == CH_COLON) return 1;
      if (lbuf[i] == CH_EQ) return 2;
    end
    return 0;
  endfunction

  function automatic void tokenize(bit eof);
    logic [7:0] c0, c1;
    bit stop;
    int r;
    forever begin
      if (done) return;
      if (lphase == LP_DROP) begin
        if (lcnt == 0) begin
          if (eof) finish_parse();
          return;
        end
        c0 = lbuf[0];
        eat(1);
        if (c0 == CH_NL) lphase = LP_CHECK;
        continue;
      end
      if (wopen) begin
        if (!(eof || lcnt >= 1)) return;
        c0 = peek_at(0);
        c1 = '0;
        if (c0 == CH_COLON || c0 == CH_BSL) begin
          if (!(eof || lcnt >= 2)) return;
          c1 = peek_at(1);
        end
        if (c0 == CH_PAD || is_sep(c0) || c0 == CH_BAR) end_word();
        else if (c0 == CH_COLON) begin
          if (c1 == CH_SLASH || c1 == CH_BSL) begin
            eat(1); push_char(CH_COLON);
          end else end_word();
        end else if (c0 == CH_BSL) begin
          if (c1 == CH_SP) begin
            eat(2); push_char(CH_SP);
          end else if (c1 == CH_CR || c1 == CH_NL) end_word();
          else begin
            eat(1); push_char(CH_SLASH);
          end
        end else begin
          eat(1); push_char(c0);
        end
        continue;
      end
      stop = 0;
      forever begin
        if (!(eof || lcnt >= 1)) begin stop = 1; break; end
        c0 = peek_at(0);
        if (is_blank(c0)) begin eat(1); continue; end
        if (c0 == CH_BSL) begin
          if (!(eof || lcnt >= 2)) begin stop = 1; break; end
          c1 = peek_at(1);
          if (c1 == CH_NL) begin eat(2); continue; end
          if (c1 == CH_CR) begin
            if (!(eof || lcnt >= 3)) begin stop = 1; break; end
            eat(2);
            if (peek_at(0) == CH_NL) eat(1);
            continue;
          end
        end
        break;
      end
      if (stop) return;
      if (sec == SEC_TARGET) begin
        if (lcnt == 0 && eof) begin finish_parse(); return; end
        if (lphase == LP_CHECK) begin
          r = decide_line();
          if (r == 2) begin lphase = LP_DROP; continue; end
          if (r == 0 && !eof) begin
            if (lcnt >= LMAX) lphase = LP_OFF;
            else return;
          end
        end
      end
      c0 = peek_at(0);
      if (c0 == CH_PAD) begin finish_parse(); return; end
      if (c0 == CH_COLON) begin eat(1); sec = SEC_DEPS; continue; end
      if (c0 == CH_BAR) begin eat(1); sec = SEC_ORDER; continue; end
      if (c0 == CH_CR || c0 == CH_NL) begin
        if (c0 == CH_CR) begin
          if (!(eof || lcnt >= 2)) return;
          eat(1);
          if (peek_at(0) == CH_NL) eat(1);
        end else eat(1);
        sec = SEC_TARGET;
        phony = 1'b0;
        lphase = LP_CHECK;
        continue;
      end
      wopen = 1'b1;
      pmatch = '0;
      held = '0;
    end
  endfunction

  function automatic void predict(logic [7:0] b, bit eof);
    step_out.delete();
    if (done) return;
    if (!eof && lcnt < LMAX) begin
      lbuf[lcnt] = b;
      lcnt++;
    end
    tokenize(eof);
    if (step_out.size() > 0) step_out[step_out.size() - 1].run_last = 1'b1;
    foreach (step_out[i]) tokens_due.push_back(step_out[i]);
  endfunction

  function automatic void model_reset();
    lcnt = 0; sec = SEC_TARGET; phony = 0; lphase = LP_CHECK;
    held = '0; pmatch = '0; wopen = 0; done = 0;
  endfunction

  task automatic send_byte(logic [7:0] b, bit eof = 0);
    while ($urandom_range(99) < send_idle_pct) begin
      byte_valid <= 1'b0;
      @(posedge clk);
    end
    byte_valid <= 1'b1;
    byte_item <= '{in_byte: b, end_of_input: eof};
    @(posedge clk);
    while (byte_stall) @(posedge clk);
    predict(b, eof);
    words_sent++;
  endtask

  task automatic send_text(string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i]);
  endtask

  task automatic drain();
    byte_valid <= 1'b0;
    while (tokens_due.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  // checks every token against the oldest expectation
  always @(posedge clk) begin
    if (!rst && token_valid && !token_stall) begin
      tokens_seen++;
      if (tokens_due.size() == 0) begin
        $error("unexpected token %p", token_item);
        errors++;
      end else begin
        out_item_t e;
        e = tokens_due.pop_front();
        if (token_item.path_char !== e.path_char) begin
          $error("path_char exp %h got %h", e.path_char, token_item.path_char); errors++;
        end
        if (token_item.item_kind !== e.item_kind) begin
          $error("item_kind exp %0d got %0d", e.item_kind, token_item.item_kind); errors++;
        end
        if (token_item.word_last !== e.word_last) begin
          $error("word_last exp %0d got %0d", e.word_last, token_item.word_last); errors++;
        end
        if (token_item.finished !== e.finished) begin
          $error("finished exp %0d got %0d", e.finished, token_item.finished); errors++;
        end
        if (token_item.run_last !== e.run_last) begin
          $error("run_last exp %0d got %0d", e.run_last, token_item.run_last); errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (hold_off) token_stall <= 1'b1;
    else token_stall <= ($urandom_range(99) < recv_idle_pct);
  end

  task automatic restart();
    drain();
    model_reset();
    // a fresh file needs the block back in reset state; this task drains and
    // resets the model only; after end of file, bytes are taken but ignored
  endtask

  function automatic logic [7:0] rand_path_byte();
    int k;
    k = $urandom_range(19);
    case (k)
      0: return CH_BSL;
      1: return CH_COLON;
      2: return CH_SP;
      3: return CH_TAB;
      4: return CH_VT;
      5: return CH_FF;
      6: return CH_BAR;
      7: return CH_NL;
      default: return 8'($urandom_range(8'h21, 8'h7E));
    endcase
  endfunction

  task automatic test_directed();
    send_text("a.o: a.c b\\ c.h C:\\x\\y.h | dir\n");
    send_text(".PHONY: all\r\n");
    send_text("X = 1 2: 3\n");
    send_text("t\\\n : \\\r\n d\x0b e\x0c|f\n");
    send_byte(8'h80); send_byte(8'h01); send_byte(8'h7F);
    send_text(":q\n");
  endtask

  task automatic test_random_rules(int n);
    int sent;
    sent = 0;
    while (sent < n) begin
      case ($urandom_range(9))
        0: begin send_text("VAR="); sent += 4; end
        1: begin send_text(".PHONY:"); sent += 7; end
        2: begin
          for (int i = 0; i < LMAX + 2; i++) send_byte("x");
          sent += LMAX + 2;
        end
        3: begin send_byte(8'($urandom)); sent++; end
        default: begin
          for (int i = $urandom_range(1, 6); i > 0; i--) begin
            send_byte(rand_path_byte()); sent++;
          end
          if ($urandom_range(2) == 0) begin send_text(": "); sent += 2; end
          if ($urandom_range(4) == 0) begin send_byte(CH_NL); sent++; end
        end
      endcase
    end
  endtask

  task automatic test_backpressure();
    hold_off = 1;
    fork
      begin
        repeat (300) @(posedge clk);
        hold_off = 0;
      end
      send_text("long/path/name.o : dep1.c dep2.h\n");
    join
  endtask

  task automatic test_end_of_file();
    send_text("last: tail");
    send_byte(8'h00, 1);
    send_byte("z");
    send_byte(8'h00, 1);
  endtask

  initial begin
    model_reset();
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    send_idle_pct = 27; recv_idle_pct = 58;
    test_random_rules(25);
    send_idle_pct = 58; recv_idle_pct = 27;
    test_random_rules(25);
    send_idle_pct = 0; recv_idle_pct = 0;
    test_backpressure();
    test_random_rules(25);
    test_end_of_file();
    drain();
    $display("Sent %0d bytes, checked %0d tokens across rules, assignments,",
             words_sent, tokens_seen);
    $display("continuations, long lines, stalls and end of file.");
    if (errors == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

  initial begin
    #20ms;
    $display("== FAIL ==");
    $finish;
  end

endmodule

`default_nettype wire
